FILE: sv/bracket_segment_tree_top_defines.svh
// Assertion macros shared by the checker of the bracket segment tree.
// Needs a clock i_clk and an active-low reset i_rst_n in the scope of use.
`ifndef BRACKET_SEGMENT_TREE_TOP_DEFINES_SVH
`define BRACKET_SEGMENT_TREE_TOP_DEFINES_SVH

// Same-cycle implication, muted while reset is held.
`define BST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bst_pkg.sv
// Shared types, codes and constants of the bracket segment tree.
// No dependencies; imported by the controller, the datapath, the top level and the checker.
`default_nettype none

package bst_pkg;

    localparam int POS_W      = 11;   // position and range end fields
    localparam int SEQ_W      = 11;   // sequence length register
    localparam int OUT_W      = 11;   // unmatched count field
    localparam int DEF_LEAVES = 1024;

    localparam logic [SEQ_W-1:0] SEQ_RESET = 11'd1024;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_FLIP  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_FLIP_WR,
        ST_UP_RD,
        ST_UP_WR,
        ST_Q_LO,
        ST_Q_HI,
        ST_Q_SH,
        ST_Q_FIN,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic in_load;   // latch an input beat
        logic clr_wr;    // zero one node of the clearing sweep
        logic leaf_wr;   // write a fresh bracket into its leaf
        logic leaf_rd;   // read a leaf ahead of a flip
        logic flip_wr;   // write back the swapped leaf
        logic sib_rd;    // read the sibling of the current node
        logic par_wr;    // write the joined parent, climb one level
        logic q_init;    // load query bounds, clear partial spans
        logic lo_step;   // read node lo, advance lo
        logic hi_step;   // retreat hi, read node hi
        logic take_l;    // fold read data into the left span
        logic take_r;    // fold read data into the right span
        logic shift;     // halve both bounds
        logic fin;       // join left and right spans
        logic out_load;  // load the result register
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       pos_ok;
        logic       q_ok;
        logic       clr_last;
        logic       node_root;
        logic       lo_lt_hi;
        logic       lo_odd;
        logic       hi_odd;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: sv/bst_ctrl.sv
// Controller of the bracket segment tree: sequences clear, update and query walks.
// Depends on bst_pkg; drives bst_datapath through t_cmd and reads t_status.
`default_nettype none

module bst_ctrl
    import bst_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_take_l, n_take_l;
    logic   r_take_r, n_take_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_take_l <= 1'b0;
            r_take_r <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_take_l <= n_take_l;
            r_take_r <= n_take_r;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (i_status.clr_last) n_state = ST_IDLE;
            ST_IDLE:    if (i_in_valid) n_state = ST_DECODE;
            ST_DECODE: begin
                case (i_status.action)
                    ACT_WRITE: n_state = i_status.pos_ok ? ST_UP_RD : ST_IDLE;
                    ACT_FLIP:  n_state = i_status.pos_ok ? ST_FLIP_WR : ST_IDLE;
                    ACT_QUERY: n_state = i_status.q_ok ? ST_Q_LO : ST_OUT;
                    default:   n_state = ST_IDLE;
                endcase
            end
            ST_FLIP_WR: n_state = ST_UP_RD;
            ST_UP_RD:   n_state = i_status.node_root ? ST_IDLE : ST_UP_WR;
            ST_UP_WR:   n_state = ST_UP_RD;
            ST_Q_LO:    n_state = i_status.lo_lt_hi ? ST_Q_HI : ST_Q_FIN;
            ST_Q_HI:    n_state = ST_Q_SH;
            ST_Q_SH:    n_state = ST_Q_LO;
            ST_Q_FIN:   n_state = ST_OUT;
            ST_OUT:     if (i_status.out_free) n_state = ST_IDLE;
            default:    n_state = ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_CLEAR:   o_cmd.clr_wr = 1'b1;
            ST_IDLE:    o_cmd.in_load = i_in_valid;
            ST_DECODE: begin
                case (i_status.action)
                    ACT_WRITE: o_cmd.leaf_wr = i_status.pos_ok;
                    ACT_FLIP:  o_cmd.leaf_rd = i_status.pos_ok;
                    ACT_QUERY: o_cmd.q_init  = i_status.q_ok;
                    default:   o_cmd = '0;
                endcase
            end
            ST_FLIP_WR: o_cmd.flip_wr = 1'b1;
            ST_UP_RD:   o_cmd.sib_rd  = !i_status.node_root;
            ST_UP_WR:   o_cmd.par_wr  = 1'b1;
            ST_Q_LO:    o_cmd.lo_step = i_status.lo_lt_hi && i_status.lo_odd;
            ST_Q_HI: begin
                o_cmd.take_l  = r_take_l;
                o_cmd.hi_step = i_status.hi_odd;
            end
            ST_Q_SH: begin
                o_cmd.take_r = r_take_r;
                o_cmd.shift  = 1'b1;
            end
            ST_Q_FIN:   o_cmd.fin = 1'b1;
            ST_OUT:     o_cmd.out_load = i_status.out_free;
            default:    o_cmd = '0;
        endcase
    end

    // remember which reads of this level are in flight
    assign n_take_l = o_cmd.lo_step;
    assign n_take_r = o_cmd.hi_step;

endmodule

`default_nettype wire

FILE: sv/bst_datapath.sv
// Datapath of the bracket segment tree: node memory, join unit, walk registers, result register.
// Depends on bst_pkg; commanded by bst_ctrl.
`default_nettype none

module bst_datapath
    import bst_pkg::*;
#(
    parameter int LEAVES = DEF_LEAVES
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  wire               i_cfg_we,
    input  wire [SEQ_W-1:0]   i_cfg_data,
    input  wire [1:0]         i_action,
    input  wire [POS_W-1:0]   i_position,
    input  wire [POS_W-1:0]   i_range_end,
    input  wire               i_bracket_open,
    input  wire               i_out_stall,
    output logic              o_out_valid,
    output logic [OUT_W-1:0]  o_unmatched_count,
    output logic              o_range_error
);

    localparam int NODES  = 2 * LEAVES;
    localparam int NODE_W = $clog2(NODES);
    localparam int IDX_W  = NODE_W + 1;
    localparam int CNT_W  = $clog2(LEAVES + 1);
    localparam int IW     = (NODE_W > POS_W) ? NODE_W : POS_W;
    localparam int LW     = IW + 1;
    localparam int SUM_W  = CNT_W + 1;
    localparam int WIDE_W = (SUM_W > OUT_W) ? SUM_W : OUT_W;

    typedef struct packed {
        logic [CNT_W-1:0] opn;
        logic [CNT_W-1:0] cls;
    } t_span;

    function automatic t_span f_join(input t_span a, input t_span b);
        t_span            r;
        logic [CNT_W-1:0] m;
        m     = (a.opn < b.cls) ? a.opn : b.cls;
        r.opn = a.opn + b.opn - m;
        r.cls = a.cls + b.cls - m;
        return r;
    endfunction

    t_span r_mem [NODES];
    t_span r_rd;

    logic [1:0]        r_action;
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  r_end;
    logic              r_open;
    logic [SEQ_W-1:0]  r_seq_len;
    logic [NODE_W-1:0] r_clr_addr;
    logic [NODE_W-1:0] r_node;
    logic [IDX_W-1:0]  r_lo;
    logic [IDX_W-1:0]  r_hi;
    t_span             r_cur;
    t_span             r_left;
    t_span             r_right;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_cnt;
    logic              r_out_err;

    logic [LW-1:0]     lo0, hi0;
    logic [NODE_W-1:0] leaf;
    logic [IDX_W-1:0]  hi_dec;
    logic              pos_ok, q_ok;
    t_span             leaf_span, flip_span;
    t_span             ja, jb, j_out;
    logic              mem_we;
    logic [NODE_W-1:0] mem_addr;
    t_span             mem_wdata;
    logic [SUM_W-1:0]  sum;
    logic [WIDE_W-1:0] sum_wide;

    // range checks and leaf index
    assign pos_ok = (r_pos != '0) && (IW'(r_pos) <= IW'(LEAVES));
    assign q_ok   = (r_pos != '0) && (r_end >= r_pos) && (r_end <= r_seq_len)
                    && (IW'(r_end) <= IW'(LEAVES));
    assign lo0    = LW'(LEAVES) + LW'(r_pos) - LW'(1);
    assign hi0    = LW'(LEAVES) + LW'(r_end);
    assign leaf   = lo0[NODE_W-1:0];
    assign hi_dec = r_hi - IDX_W'(1);

    assign leaf_span.opn = {{(CNT_W-1){1'b0}}, r_open};
    assign leaf_span.cls = {{(CNT_W-1){1'b0}}, !r_open};
    assign flip_span.opn = r_rd.cls;
    assign flip_span.cls = r_rd.opn;

    // one shared join unit
    always_comb begin
        ja = r_cur;
        jb = r_rd;
        if (i_cmd.par_wr && r_node[0]) begin
            ja = r_rd;
            jb = r_cur;
        end else if (i_cmd.take_l) begin
            ja = r_left;
            jb = r_rd;
        end else if (i_cmd.take_r) begin
            ja = r_rd;
            jb = r_right;
        end else if (i_cmd.fin) begin
            ja = r_left;
            jb = r_right;
        end
    end
    assign j_out = f_join(ja, jb);

    // memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_node;
        mem_wdata = j_out;
        if (i_cmd.clr_wr) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr_addr;
            mem_wdata = '0;
        end else if (i_cmd.leaf_wr) begin
            mem_we    = 1'b1;
            mem_addr  = leaf;
            mem_wdata = leaf_span;
        end else if (i_cmd.leaf_rd) begin
            mem_addr  = leaf;
        end else if (i_cmd.flip_wr) begin
            mem_we    = 1'b1;
            mem_addr  = leaf;
            mem_wdata = flip_span;
        end else if (i_cmd.sib_rd) begin
            mem_addr  = r_node ^ NODE_W'(1);
        end else if (i_cmd.par_wr) begin
            mem_we    = 1'b1;
            mem_addr  = r_node >> 1;
        end else if (i_cmd.lo_step) begin
            mem_addr  = r_lo[NODE_W-1:0];
        end else if (i_cmd.hi_step) begin
            mem_addr  = hi_dec[NODE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_addr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_len   <= SEQ_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seq_len <= i_cfg_data;
            end
            if (i_cmd.clr_wr) begin
                r_clr_addr <= r_clr_addr + NODE_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and walk registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_action <= i_action;
            r_pos    <= i_position;
            r_end    <= i_range_end;
            r_open   <= i_bracket_open;
        end
        if (i_cmd.leaf_wr) begin
            r_node <= leaf;
            r_cur  <= leaf_span;
        end else if (i_cmd.flip_wr) begin
            r_node <= leaf;
            r_cur  <= flip_span;
        end else if (i_cmd.par_wr) begin
            r_node <= r_node >> 1;
            r_cur  <= j_out;
        end
        if (i_cmd.q_init) begin
            r_lo    <= lo0[IDX_W-1:0];
            r_hi    <= hi0[IDX_W-1:0];
            r_left  <= '0;
            r_right <= '0;
        end else begin
            if (i_cmd.lo_step) begin
                r_lo <= r_lo + IDX_W'(1);
            end
            if (i_cmd.hi_step) begin
                r_hi <= hi_dec;
            end
            if (i_cmd.shift) begin
                r_lo <= r_lo >> 1;
                r_hi <= r_hi >> 1;
            end
            if (i_cmd.take_l || i_cmd.fin) begin
                r_left <= j_out;
            end
            if (i_cmd.take_r) begin
                r_right <= j_out;
            end
        end
        if (i_cmd.out_load) begin
            r_out_cnt <= q_ok ? sum_wide[OUT_W-1:0] : '0;
            r_out_err <= !q_ok;
        end
    end

    assign sum      = {1'b0, r_left.opn} + {1'b0, r_left.cls};
    assign sum_wide = WIDE_W'(sum);

    assign o_status.action    = r_action;
    assign o_status.pos_ok    = pos_ok;
    assign o_status.q_ok      = q_ok;
    assign o_status.clr_last  = (r_clr_addr == NODE_W'(NODES - 1));
    assign o_status.node_root = (r_node == NODE_W'(1));
    assign o_status.lo_lt_hi  = (r_lo < r_hi);
    assign o_status.lo_odd    = r_lo[0];
    assign o_status.hi_odd    = r_hi[0];
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_unmatched_count = r_out_cnt;
    assign o_range_error     = r_out_err;

endmodule

`default_nettype wire

FILE: sv/bracket_segment_tree_top.sv
// Bracket segment tree: the top level joining the controller and the datapath.
// Depends on bst_pkg, bst_ctrl and bst_datapath.
//
// Keeps a string of LEAVES bracket positions in a segment tree of 2*LEAVES
// nodes, each node holding its span's unmatched opening and closing counts in
// one single-port memory. A write or flip beat changes one leaf and then climbs
// to the root, one sibling read and one parent write per level; a flip first
// reads its leaf and writes it back swapped. A query beat walks the bounds
// upward, up to two node reads per level, plus decode, final join and result
// load; a rejected range goes straight to the result load. The single memory
// port serializes all these reads and writes. After reset the block sweeps the
// memory to zero, one node a cycle, taking no beat until the sweep ends;
// configuration writes are taken throughout. Only a query returns a beat; its
// result waits in an output register while the next beat is taken and worked
// on. Write seq_length only while idle.
`default_nettype none

module bracket_segment_tree_top
    import bst_pkg::*;
#(
    parameter int LEAVES = DEF_LEAVES
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    // configuration: sequence length
    input  wire              i_cfg_we,
    input  wire [SEQ_W-1:0]  i_cfg_data,
    // input channel
    input  wire              i_in_valid,
    output logic             o_in_stall,
    input  wire [1:0]        i_action,
    input  wire [POS_W-1:0]  i_position,
    input  wire [POS_W-1:0]  i_range_end,
    input  wire              i_bracket_open,
    // result channel
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output logic [OUT_W-1:0] o_unmatched_count,
    output logic             o_range_error
);

    t_cmd    cmd;
    t_status status;

    // sequence the walks; hold the input side while busy
    bst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // node memory, join unit and the result register
    bst_datapath #(
        .LEAVES (LEAVES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_action          (i_action),
        .i_position        (i_position),
        .i_range_end       (i_range_end),
        .i_bracket_open    (i_bracket_open),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_unmatched_count (o_unmatched_count),
        .o_range_error     (o_range_error)
    );

endmodule

`default_nettype wire

FILE: sv/bst_checker.sv
// Port-level checks of the bracket segment tree, bound to the top level.
// Depends on bst_pkg and bracket_segment_tree_top_defines.svh.
`default_nettype none

`include "bracket_segment_tree_top_defines.svh"

module bst_checker
    import bst_pkg::*;
#(
    parameter int LEAVES = DEF_LEAVES
) (
    input wire             i_clk,
    input wire             i_rst_n,
    input wire             i_in_valid,
    input wire             o_in_stall,
    input wire             o_out_valid,
    input wire             i_out_stall,
    input wire [OUT_W-1:0] o_unmatched_count,
    input wire             o_range_error
);

    // one beat at a time: busy straight after an accept
    `BST_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "accepted beat did not hold the input side")

    // a result only appears at the end of a busy spell
    `BST_ASSERT_NOW(a_result_from_busy, $rose(o_out_valid), $past(o_in_stall), "result appeared without a preceding walk")

    // a rejected range carries no count
    `BST_ASSERT_NOW(a_error_zero_count, o_out_valid && o_range_error, o_unmatched_count == '0, "rejected range reported a count")

    // a stalled result holds
    `BST_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_unmatched_count) && $stable(o_range_error), "stalled result changed")

    // no span can hold more unmatched brackets than there are leaves
    `BST_ASSERT_NOW(a_count_bound, o_out_valid, int'(o_unmatched_count) <= LEAVES, "unmatched count above leaf count")

endmodule

bind bracket_segment_tree_top bst_checker #(.LEAVES(LEAVES)) u_bst_checker (.*);

`default_nettype wire
